// ----- sv/invert_upper_3x3_assert.svh -----
// Assertion macros shared by the invert_upper_3x3 RTL.
`ifndef INVERT_UPPER_3X3_ASSERT_SVH
`define INVERT_UPPER_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define INV3_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("inv3 assertion failed");
`define INV3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("inv3 assertion failed");
`else
`define INV3_ASSERT(lbl, clk, rst, ante, cons)
`define INV3_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/inv3_pkg.sv -----
// Types and constants of the 3x3 matrix inverse pipeline.
package inv3_pkg;

   localparam int ENTRY_W = 16;
   localparam int PROD_W  = 32;
   localparam int COF_W   = 33;
   localparam int TERM_W  = 49;
   localparam int DET_W   = 50;
   localparam int QUOT_W  = 32;
   localparam int FRAC_SHIFT = 28;   // Q8.24 / Q12.36 -> Q16.16
   localparam int DIV_LAT  = QUOT_W + 2;
   localparam int FRONT_LAT = 5;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a00;
      logic signed [ENTRY_W-1:0] a01;
      logic signed [ENTRY_W-1:0] a02;
      logic signed [ENTRY_W-1:0] a10;
      logic signed [ENTRY_W-1:0] a11;
      logic signed [ENTRY_W-1:0] a12;
      logic signed [ENTRY_W-1:0] a20;
      logic signed [ENTRY_W-1:0] a21;
      logic signed [ENTRY_W-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [QUOT_W-1:0] r00;
      logic signed [QUOT_W-1:0] r01;
      logic signed [QUOT_W-1:0] r02;
      logic signed [QUOT_W-1:0] r10;
      logic signed [QUOT_W-1:0] r11;
      logic signed [QUOT_W-1:0] r12;
      logic signed [QUOT_W-1:0] r20;
      logic signed [QUOT_W-1:0] r21;
      logic signed [QUOT_W-1:0] r22;
      logic                     singular;
      logic                     clipped;
   } rsp_type;

   localparam logic [QUOT_W-1:0] POS_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] NEG_MAX = {1'b1, {(QUOT_W-1){1'b0}}};

endpackage

// ----- sv/inv3_div.sv -----
// Pipelined signed divider: trunc(cof * 2^28 / det), saturated to 32 bits.
module inv3_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [inv3_pkg::COF_W-1:0]  cof,
   input  logic signed [inv3_pkg::DET_W-1:0]  det,
   output logic                               out_valid,
   output logic signed [inv3_pkg::QUOT_W-1:0] out_quot,
   output logic                               out_clip,
   output logic                               out_zero
);
   import inv3_pkg::*;
   `include "invert_upper_3x3_assert.svh"

   localparam int NUM_W = COF_W + FRAC_SHIFT;
   localparam int HI_W  = NUM_W - QUOT_W;

   logic [COF_W-1:0]  abs_cof;
   logic [DET_W-1:0]  abs_det;
   logic [NUM_W-1:0]  num_full;
   logic [HI_W-1:0]   num_hi;

   logic              vld_ff  [0:QUOT_W];
   logic [DET_W-1:0]  rem_ff  [0:QUOT_W];
   logic [DET_W-1:0]  den_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] num_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff    [0:QUOT_W];
   logic              neg_ff  [0:QUOT_W];
   logic              ovf_ff  [0:QUOT_W];
   logic              zero_ff [0:QUOT_W];

   logic                     out_vld_ff;
   logic signed [QUOT_W-1:0] out_quot_ff, out_quot_in;
   logic                     out_clip_ff, out_clip_in;
   logic                     out_zero_ff;

   always_comb begin
      abs_cof  = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
      abs_det  = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
      num_full = {abs_cof, {FRAC_SHIFT{1'b0}}};
      num_hi   = num_full[NUM_W-1:QUOT_W];
   end

   // quotient would need more than 32 magnitude bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= DET_W'(num_hi);
      den_ff[0]  <= abs_det;
      num_ff[0]  <= num_full[QUOT_W-1:0];
      q_ff[0]    <= '0;
      neg_ff[0]  <= cof[COF_W-1] ^ det[DET_W-1];
      ovf_ff[0]  <= DET_W'(num_hi) >= abs_det;
      zero_ff[0] <= (det == '0);
   end

   for (genvar s = 0; s < QUOT_W; s++) begin : g_step
      logic [DET_W:0] trial;
      logic           ge;
      always_comb begin
         trial = {rem_ff[s], num_ff[s][QUOT_W-1]};
         ge    = trial >= {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         rem_ff[s+1]  <= ge ? DET_W'(trial - {1'b0, den_ff[s]}) : trial[DET_W-1:0];
         den_ff[s+1]  <= den_ff[s];
         num_ff[s+1]  <= {num_ff[s][QUOT_W-2:0], 1'b0};
         q_ff[s+1]    <= {q_ff[s][QUOT_W-2:0], ge};
         neg_ff[s+1]  <= neg_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   always_comb begin
      out_quot_in = '0;
      out_clip_in = 1'b0;
      if (zero_ff[QUOT_W]) begin
         out_quot_in = '0;
      end else if (!neg_ff[QUOT_W]) begin
         if (ovf_ff[QUOT_W] || q_ff[QUOT_W] > POS_MAX) begin
            out_quot_in = POS_MAX;
            out_clip_in = 1'b1;
         end else begin
            out_quot_in = q_ff[QUOT_W];
         end
      end else begin
         if (ovf_ff[QUOT_W] || q_ff[QUOT_W] > NEG_MAX) begin
            out_quot_in = NEG_MAX;
            out_clip_in = 1'b1;
         end else begin
            out_quot_in = -q_ff[QUOT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[QUOT_W];
      end
      out_quot_ff <= out_quot_in;
      out_clip_ff <= out_clip_in;
      out_zero_ff <= zero_ff[QUOT_W];
   end

   assign out_valid = out_vld_ff;
   assign out_quot  = out_quot_ff;
   assign out_clip  = out_clip_ff;
   assign out_zero  = out_zero_ff;

   `INV3_ASSERT(a_rem_below_den, clock, reset, vld_ff[QUOT_W] && !zero_ff[QUOT_W] && !ovf_ff[QUOT_W], rem_ff[QUOT_W] < den_ff[QUOT_W])
   `INV3_ASSERT(a_latency, clock, reset, out_valid, $past(in_valid, DIV_LAT))
   `INV3_ASSERT_NEXT(a_zero_out, clock, reset, vld_ff[QUOT_W] && zero_ff[QUOT_W], out_quot == 0 && !out_clip)

endmodule

// ----- sv/invert_upper_3x3.sv -----
// Top level: 3x3 matrix inverse by adjugate over determinant, fully pipelined.
// Takes one matrix per clock and returns its inverse through the stages below;
// busy is always low. Each result beat sits on rsp_data for one cycle with
// rsp_strobe high, and there is no way to hold it off, so the receiver must take
// every beat as it comes. Five stages form products, cofactors and
// the determinant, then nine parallel 32-stage restoring dividers (one quotient
// bit per stage) with their input and saturation registers form the quotients.
// A zero determinant gives all-zero entries with singular set; a quotient that
// does not fit signed Q16.16 is saturated and sets clipped.
module invert_upper_3x3 (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  inv3_pkg::req_type req_data,
   output logic              rsp_strobe,
   output inv3_pkg::rsp_type rsp_data
);
   import inv3_pkg::*;
   `include "invert_upper_3x3_assert.svh"

   localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

   logic accept;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   req_type                   m_ff;
   logic signed [PROD_W-1:0]  p_ff   [18];
   logic signed [PROD_W-1:0]  p_in   [18];
   logic signed [ENTRY_W-1:0] m0_2_ff, m1_2_ff, m2_2_ff;
   logic signed [ENTRY_W-1:0] m0_3_ff, m1_3_ff, m2_3_ff;
   logic signed [COF_W-1:0]   adj3_ff [9];
   logic signed [COF_W-1:0]   adj4_ff [9];
   logic signed [COF_W-1:0]   adj5_ff [9];
   logic signed [TERM_W-1:0]  t_ff   [3];
   logic signed [DET_W-1:0]   det_ff, det_in;

   logic                      dv   [9];
   logic signed [QUOT_W-1:0]  dq   [9];
   logic                      dclp [9];
   logic                      dzer [9];
   logic                      any_clip;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      p_in[0]  = m_ff.a11 * m_ff.a22;  p_in[1]  = m_ff.a21 * m_ff.a12;
      p_in[2]  = m_ff.a02 * m_ff.a21;  p_in[3]  = m_ff.a01 * m_ff.a22;
      p_in[4]  = m_ff.a01 * m_ff.a12;  p_in[5]  = m_ff.a02 * m_ff.a11;
      p_in[6]  = m_ff.a12 * m_ff.a20;  p_in[7]  = m_ff.a10 * m_ff.a22;
      p_in[8]  = m_ff.a00 * m_ff.a22;  p_in[9]  = m_ff.a02 * m_ff.a20;
      p_in[10] = m_ff.a10 * m_ff.a02;  p_in[11] = m_ff.a00 * m_ff.a12;
      p_in[12] = m_ff.a10 * m_ff.a21;  p_in[13] = m_ff.a20 * m_ff.a11;
      p_in[14] = m_ff.a20 * m_ff.a01;  p_in[15] = m_ff.a00 * m_ff.a21;
      p_in[16] = m_ff.a00 * m_ff.a11;  p_in[17] = m_ff.a10 * m_ff.a01;
      det_in = DET_W'(t_ff[0]) + DET_W'(t_ff[1]) + DET_W'(t_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      m_ff    <= req_data;
      p_ff    <= p_in;
      m0_2_ff <= m_ff.a00;
      m1_2_ff <= m_ff.a01;
      m2_2_ff <= m_ff.a02;
      for (int k = 0; k < 9; k++) begin
         adj3_ff[k] <= COF_W'(p_ff[2*k]) - COF_W'(p_ff[2*k+1]);
      end
      m0_3_ff <= m0_2_ff;
      m1_3_ff <= m1_2_ff;
      m2_3_ff <= m2_2_ff;
      t_ff[0] <= m0_3_ff * adj3_ff[0];
      t_ff[1] <= m1_3_ff * adj3_ff[3];
      t_ff[2] <= m2_3_ff * adj3_ff[6];
      adj4_ff <= adj3_ff;
      det_ff  <= det_in;
      adj5_ff <= adj4_ff;
   end

   for (genvar k = 0; k < 9; k++) begin : g_div
      inv3_div u_div (
         .clock    (clock),
         .reset    (reset),
         .in_valid (v5_ff),
         .cof      (adj5_ff[k]),
         .det      (det_ff),
         .out_valid(dv[k]),
         .out_quot (dq[k]),
         .out_clip (dclp[k]),
         .out_zero (dzer[k])
      );
   end

   always_comb begin
      any_clip = 1'b0;
      for (int k = 0; k < 9; k++) begin
         any_clip = any_clip | dclp[k];
      end
   end

   assign rsp_strobe        = dv[0];
   assign rsp_data.r00      = dq[0];
   assign rsp_data.r01      = dq[1];
   assign rsp_data.r02      = dq[2];
   assign rsp_data.r10      = dq[3];
   assign rsp_data.r11      = dq[4];
   assign rsp_data.r12      = dq[5];
   assign rsp_data.r20      = dq[6];
   assign rsp_data.r21      = dq[7];
   assign rsp_data.r22      = dq[8];
   assign rsp_data.singular = dzer[0];
   assign rsp_data.clipped  = any_clip && !dzer[0];

   `INV3_ASSERT(a_total_latency, clock, reset, rsp_strobe, $past(accept, TOTAL_LAT))
   `INV3_ASSERT(a_singular_zero, clock, reset, rsp_strobe && rsp_data.singular, rsp_data.r00 == 0 && rsp_data.r11 == 0 && rsp_data.r22 == 0 && !rsp_data.clipped)
   `INV3_ASSERT(a_det_zero_flag, clock, reset, v5_ff && det_ff == 0, ##DIV_LAT (rsp_strobe && rsp_data.singular))

endmodule
